// ===== design/cfr_pkg.sv =====
// Shared types and constants for the COBS frame receiver.
// No dependencies; every other file of the block imports this package.
package cfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;

   localparam logic [BYTE_W-1:0] DELIM       = 8'h00;
   localparam logic [BYTE_W-1:0] CODE_NOZERO = 8'hFF;
   localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

   typedef enum logic {
      UNS_IDLE,
      UNS_RUN
   } uns_state_type;

   typedef enum logic {
      EMT_IDLE,
      EMT_RUN
   } emit_state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic keep;
   } uns_status_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic empty;
   } emit_tag_type;

endpackage

// ===== design/cfr_raw_buf.sv =====
// Raw frame buffer: one-port-write, one-port-read byte memory, fill count and
// discard flag. Depends on cfr_pkg.
module cfr_raw_buf import cfr_pkg::*; #(
   parameter int RAW_MAX = 66,
   localparam int RAW_AW = $clog2(RAW_MAX),
   localparam int RCW    = $clog2(RAW_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              rd_en,
   input  logic [RAW_AW-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data,
   output logic              frame_go,
   output logic [RCW-1:0]    frame_len
);

   localparam logic [RCW-1:0] RAW_FULL = RCW'(RAW_MAX);

   logic [BYTE_W-1:0] mem_ff [RAW_MAX];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [RCW-1:0]    count_ff, count_in;
   logic              discard_ff, discard_in;
   logic              wr_en;

   always_comb begin
      count_in   = count_ff;
      discard_in = discard_ff;
      wr_en      = 1'b0;
      frame_go   = 1'b0;
      if (accept) begin
         if (rx_byte != DELIM) begin
            if (!discard_ff) begin
               if (count_ff != RAW_FULL) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + RCW'(1);
               end else begin
                  // overflow: drop the frame up to the next delimiter
                  discard_in = 1'b1;
                  count_in   = '0;
               end
            end
         end else begin
            count_in   = '0;
            discard_in = 1'b0;
            frame_go   = !discard_ff && (count_ff != '0);
         end
      end
   end

   assign frame_len = count_ff;
   assign rd_data   = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         discard_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         discard_ff <= discard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[count_ff[RAW_AW-1:0]] <= rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== design/cfr_unstuff.sv =====
// COBS unstuffing sequencer: streams the raw buffer out one byte a cycle and
// produces decoded write beats. Depends on cfr_pkg.
module cfr_unstuff import cfr_pkg::*; #(
   parameter int RAW_MAX = 66,
   parameter int DEC_MAX = 64,
   localparam int RAW_AW = $clog2(RAW_MAX),
   localparam int RCW    = $clog2(RAW_MAX + 1),
   localparam int DEC_AW = $clog2(DEC_MAX),
   localparam int DCW    = $clog2(DEC_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              frame_go,
   input  logic [RCW-1:0]    frame_len,
   output logic              raw_rd_en,
   output logic [RAW_AW-1:0] raw_rd_addr,
   input  logic [BYTE_W-1:0] raw_rd_data,
   output logic              dec_we,
   output logic [DEC_AW-1:0] dec_wr_addr,
   output logic [BYTE_W-1:0] dec_wr_data,
   output logic [DCW-1:0]    dec_len,
   output uns_status_type    status
);

   localparam logic [DCW-1:0] DEC_FULL = DCW'(DEC_MAX);

   uns_state_type     state_ff, state_in;
   logic [RCW-1:0]    len_ff, len_in;
   logic [RCW-1:0]    si_ff, si_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic              ins_ff, ins_in;
   logic [DCW-1:0]    di_ff, di_in;
   logic              ovf_ff, ovf_in;
   logic              done_ff, done_in;
   logic              put_beat;

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      si_in       = si_ff;
      pend_in     = 1'b0;
      rem_in      = rem_ff;
      ins_in      = ins_ff;
      di_in       = di_ff;
      ovf_in      = ovf_ff;
      done_in     = 1'b0;
      raw_rd_en   = 1'b0;
      raw_rd_addr = si_ff[RAW_AW-1:0];
      put_beat    = 1'b0;
      dec_wr_data = raw_rd_data;
      dec_we      = 1'b0;
      unique case (state_ff)
         UNS_IDLE: begin
            if (frame_go) begin
               state_in = UNS_RUN;
               len_in   = frame_len;
               si_in    = '0;
               rem_in   = '0;
               ins_in   = 1'b0;
               di_in    = '0;
               ovf_in   = 1'b0;
            end
         end
         UNS_RUN: begin
            if (si_ff < len_ff) begin
               raw_rd_en = 1'b1;
               si_in     = si_ff + RCW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (rem_ff == '0) begin
                  // code byte: close the previous group with a zero if it asks for one
                  rem_in      = raw_rd_data - 8'd1;
                  ins_in      = (raw_rd_data != CODE_NOZERO);
                  put_beat    = ins_ff;
                  dec_wr_data = ZERO_BYTE;
               end else begin
                  rem_in   = rem_ff - 8'd1;
                  put_beat = 1'b1;
               end
            end
            if (put_beat) begin
               if (di_ff == DEC_FULL || ovf_ff) begin
                  ovf_in = 1'b1;
               end else begin
                  dec_we = 1'b1;
                  di_in  = di_ff + DCW'(1);
               end
            end
            if (!pend_ff && (si_ff == len_ff)) begin
               state_in = UNS_IDLE;
               done_in  = 1'b1;
            end
         end
      endcase
   end

   assign dec_wr_addr = di_ff[DEC_AW-1:0];
   assign dec_len     = di_ff;
   assign status.busy = (state_ff == UNS_RUN) || done_ff;
   assign status.done = done_ff;
   assign status.keep = !ovf_ff && (di_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UNS_IDLE;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      si_ff  <= si_in;
      rem_ff <= rem_in;
      ins_ff <= ins_in;
      di_ff  <= di_in;
      ovf_ff <= ovf_in;
   end

endmodule

// ===== design/cfr_emit.sv =====
// Decoded frame store and result sequencer: holds the decoded bytes and plays
// them out as type plus payload beats. Depends on cfr_pkg.
module cfr_emit import cfr_pkg::*; #(
   parameter int DEC_MAX = 64,
   localparam int DEC_AW = $clog2(DEC_MAX),
   localparam int DCW    = $clog2(DEC_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              dec_we,
   input  logic [DEC_AW-1:0] dec_wr_addr,
   input  logic [BYTE_W-1:0] dec_wr_data,
   input  logic              go,
   input  logic [DCW-1:0]    dlen,
   output logic              busy,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_pkt_type,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic              rsp_data_valid,
   output logic [LEN_W-1:0]  rsp_payload_len,
   output logic              rsp_last
);

   logic [BYTE_W-1:0] mem_ff [DEC_MAX];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] type_ff;
   emit_state_type    state_ff, state_in;
   logic [DCW-1:0]    idx_ff, idx_in;
   logic [DCW-1:0]    plen_ff, plen_in;
   emit_tag_type      tag_ff, tag_in;
   logic              rd_en;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      plen_in  = plen_ff;
      tag_in   = '0;
      rd_en    = 1'b0;
      unique case (state_ff)
         EMT_IDLE: begin
            if (go) begin
               state_in = EMT_RUN;
               plen_in  = dlen - DCW'(1);
               idx_in   = '0;
            end
         end
         EMT_RUN: begin
            // entry zero is the type byte; entries one to plen are payload
            rd_en        = 1'b1;
            tag_in.valid = 1'b1;
            tag_in.first = (idx_ff == '0);
            tag_in.last  = (idx_ff == plen_ff);
            tag_in.empty = (plen_ff == '0);
            idx_in       = idx_ff + DCW'(1);
            if (idx_ff == plen_ff) begin
               state_in = EMT_IDLE;
            end
         end
      endcase
   end

   assign busy            = (state_ff == EMT_RUN);
   assign rsp_valid       = tag_ff.valid && (!tag_ff.first || tag_ff.empty);
   assign rsp_pkt_type    = tag_ff.first ? rd_data_ff : type_ff;
   assign rsp_data_byte   = tag_ff.empty ? ZERO_BYTE : rd_data_ff;
   assign rsp_data_valid  = !tag_ff.empty;
   assign rsp_payload_len = LEN_W'(plen_ff);
   assign rsp_last        = tag_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMT_IDLE;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      plen_ff <= plen_in;
      if (tag_ff.valid && tag_ff.first) begin
         type_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_we) begin
         mem_ff[dec_wr_addr] <= dec_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[idx_ff[DEC_AW-1:0]];
      end
   end

endmodule

// ===== design/cobs_frame_receiver_top.sv =====
// COBS frame receiver top level: wires raw buffer, unstuffer and emitter.
// Depends on cfr_pkg, cfr_raw_buf, cfr_unstuff and cfr_emit.
//
// A nonzero link byte is taken and buffered; busy stays low.
// A 0x00 delimiter that closes a buffered frame of len raw bytes raises busy
// while the unstuffer reads the raw memory one byte a cycle and then while
// the emitter reads the decoded memory one entry a cycle. The emitter gives
// one result per payload byte, or a single beat with rsp_data_valid low for
// a type-only frame, with rsp_valid high for one cycle each. Results
// cannot be held off: the receiver must take every beat as it appears. A
// dropped, empty or oversized frame gives no result beat.
module cobs_frame_receiver_top import cfr_pkg::*; #(
   parameter int DEC_MAX = 64,
   parameter int RAW_MAX = 66
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_pkt_type,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output logic              rsp_data_valid,
   output logic [LEN_W-1:0]  rsp_payload_len,
   output logic              rsp_last
);

   localparam int RAW_AW = $clog2(RAW_MAX);
   localparam int RCW    = $clog2(RAW_MAX + 1);
   localparam int DEC_AW = $clog2(DEC_MAX);
   localparam int DCW    = $clog2(DEC_MAX + 1);

   logic              accept;
   logic              raw_rd_en;
   logic [RAW_AW-1:0] raw_rd_addr;
   logic [BYTE_W-1:0] raw_rd_data;
   logic              frame_go;
   logic [RCW-1:0]    frame_len;
   logic              dec_we;
   logic [DEC_AW-1:0] dec_wr_addr;
   logic [BYTE_W-1:0] dec_wr_data;
   logic [DCW-1:0]    dec_len;
   uns_status_type    uns_status;
   logic              emit_busy;

   assign busy   = uns_status.busy || emit_busy;
   assign accept = start && !busy;

   cfr_raw_buf #(
      .RAW_MAX (RAW_MAX)
   ) u_raw_buf (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .rd_en     (raw_rd_en),
      .rd_addr   (raw_rd_addr),
      .rd_data   (raw_rd_data),
      .frame_go  (frame_go),
      .frame_len (frame_len)
   );

   cfr_unstuff #(
      .RAW_MAX (RAW_MAX),
      .DEC_MAX (DEC_MAX)
   ) u_unstuff (
      .clock       (clock),
      .reset       (reset),
      .frame_go    (frame_go),
      .frame_len   (frame_len),
      .raw_rd_en   (raw_rd_en),
      .raw_rd_addr (raw_rd_addr),
      .raw_rd_data (raw_rd_data),
      .dec_we      (dec_we),
      .dec_wr_addr (dec_wr_addr),
      .dec_wr_data (dec_wr_data),
      .dec_len     (dec_len),
      .status      (uns_status)
   );

   cfr_emit #(
      .DEC_MAX (DEC_MAX)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .dec_we          (dec_we),
      .dec_wr_addr     (dec_wr_addr),
      .dec_wr_data     (dec_wr_data),
      .go              (uns_status.done && uns_status.keep),
      .dlen            (dec_len),
      .busy            (emit_busy),
      .rsp_valid       (rsp_valid),
      .rsp_pkt_type    (rsp_pkt_type),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_payload_len (rsp_payload_len),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for cobs_frame_receiver_top: streams COBS-framed link bytes and
// checks every decoded beat against a frame predictor held in a scoreboard.
// Depends on cfr_pkg and the cobs_frame_receiver_top RTL.
module tb_top;
   import cfr_pkg::*;

   localparam int DEC_MAX = 64;
   localparam int RAW_MAX = 66;

   typedef logic [BYTE_W-1:0] byte_q_type [$];

   typedef struct packed {
      logic [BYTE_W-1:0] pkt_type;
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic [LEN_W-1:0]  payload_len;
      logic              is_last;
   } beat_type;

   class frame_scoreboard;
      logic [BYTE_W-1:0] raw_buf [RAW_MAX];
      logic [BYTE_W-1:0] dec_buf [DEC_MAX];
      int                raw_len;
      bit                dropping;
      beat_type          beats_due [$];
      int                errors;

      function new();
         raw_len  = 0;
         dropping = 0;
         errors   = 0;
      endfunction

      // Unstuff raw_buf into dec_buf; -1 when the decoded frame overflows.
      function int unstuff();
         int si;
         int di;
         int code;
         int k;
         si = 0;
         di = 0;
         while (si < raw_len) begin
            code = raw_buf[si];
            si++;
            for (k = 1; k < code; k++) begin
               if (si >= raw_len)
                  return di;
               if (di >= DEC_MAX)
                  return -1;
               dec_buf[di] = raw_buf[si];
               di++;
               si++;
            end
            if (code != CODE_NOZERO && si < raw_len) begin
               if (di >= DEC_MAX)
                  return -1;
               dec_buf[di] = ZERO_BYTE;
               di++;
            end
         end
         return di;
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         int       dlen;
         beat_type e;
         if (b != DELIM) begin
            if (dropping)
               return;
            if (raw_len < RAW_MAX) begin
               raw_buf[raw_len] = b;
               raw_len++;
            end else begin
               dropping = 1;
               raw_len  = 0;
            end
            return;
         end
         if (dropping) begin
            dropping = 0;
            raw_len  = 0;
            return;
         end
         if (raw_len == 0)
            return;
         dlen    = unstuff();
         raw_len = 0;
         if (dlen < 1)
            return;
         if (dlen == 1) begin
            e = '{pkt_type: dec_buf[0], data_byte: '0, data_valid: 1'b0,
                  payload_len: '0, is_last: 1'b1};
            beats_due.push_back(e);
            return;
         end
         for (int k = 0; k < dlen - 1; k++) begin
            e.pkt_type    = dec_buf[0];
            e.data_byte   = dec_buf[k+1];
            e.data_valid  = 1'b1;
            e.payload_len = LEN_W'(dlen - 1);
            e.is_last     = (k == dlen - 2);
            beats_due.push_back(e);
         end
      endfunction

      function void check_beat(beat_type got);
         beat_type e;
         if (beats_due.size() == 0) begin
            $error("unexpected result beat: pkt_type %0h data_byte %0h",
                   got.pkt_type, got.data_byte);
            errors++;
            return;
         end
         e = beats_due.pop_front();
         if (got.pkt_type !== e.pkt_type) begin
            $error("rsp_pkt_type: expected %0h, got %0h", e.pkt_type, got.pkt_type);
            errors++;
         end
         if (got.data_byte !== e.data_byte) begin
            $error("rsp_data_byte: expected %0h, got %0h", e.data_byte, got.data_byte);
            errors++;
         end
         if (got.data_valid !== e.data_valid) begin
            $error("rsp_data_valid: expected %0b, got %0b", e.data_valid, got.data_valid);
            errors++;
         end
         if (got.payload_len !== e.payload_len) begin
            $error("rsp_payload_len: expected %0d, got %0d",
                   e.payload_len, got.payload_len);
            errors++;
         end
         if (got.is_last !== e.is_last) begin
            $error("rsp_last: expected %0b, got %0b", e.is_last, got.is_last);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic [BYTE_W-1:0] rsp_pkt_type;
   logic [BYTE_W-1:0] rsp_data_byte;
   logic              rsp_data_valid;
   logic [LEN_W-1:0]  rsp_payload_len;
   logic              rsp_last;

   frame_scoreboard sb = new();
   bit              steady = 0;
   int              sent_cnt = 0;

   cobs_frame_receiver_top #(.DEC_MAX(DEC_MAX), .RAW_MAX(RAW_MAX)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_pkt_type    (rsp_pkt_type),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_payload_len (rsp_payload_len),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Check result beats first; an accepted byte only affects later beats.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_beat('{pkt_type: rsp_pkt_type, data_byte: rsp_data_byte,
                            data_valid: rsp_data_valid,
                            payload_len: rsp_payload_len, is_last: rsp_last});
         if (start && !busy)
            sb.note_byte(req_rx_byte);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (!steady && $urandom_range(99) < 5) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start       <= 1'b1;
      req_rx_byte <= b;
      // hold the beat until the block takes it
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
   endtask

   // Send a byte sequence; idle gaps are suppressed only while sent_cnt is 150 to 249.
   task automatic send_seq(input byte_q_type q);
      foreach (q[i]) begin
         steady = (sent_cnt >= 150 && sent_cnt < 250);
         send_byte(q[i]);
         sent_cnt++;
      end
   endtask

   function automatic void stuff_frame(input byte_q_type src, output byte_q_type dst);
      int                code_at;
      logic [BYTE_W-1:0] run;
      dst.delete();
      dst.push_back(ZERO_BYTE);
      code_at = 0;
      run     = 1;
      foreach (src[i]) begin
         if (src[i] == ZERO_BYTE) begin
            dst[code_at] = run;
            code_at      = dst.size();
            dst.push_back(ZERO_BYTE);
            run = 1;
         end else begin
            dst.push_back(src[i]);
            run++;
         end
      end
      dst[code_at] = run;
   endfunction

   task automatic send_packet(input byte_q_type data);
      byte_q_type enc;
      stuff_frame(data, enc);
      enc.push_back(DELIM);
      send_seq(enc);
   endtask

   function automatic void make_data(input int n, input int zero_pct,
                                     output byte_q_type d);
      d.delete();
      for (int i = 0; i < n; i++)
         d.push_back(($urandom_range(99) < zero_pct) ? ZERO_BYTE
                                                     : BYTE_W'($urandom_range(1, 255)));
   endfunction

   function automatic void make_noise(input int n, output byte_q_type d);
      d.delete();
      for (int i = 0; i < n; i++)
         d.push_back(BYTE_W'($urandom_range(1, 255)));
   endfunction

   initial begin
      byte_q_type q;
      int         r;
      int         n;

      reset       = 1'b1;
      start       = 1'b0;
      req_rx_byte = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty frame, then a lone code byte that decodes to nothing
      q = '{DELIM};
      send_seq(q);
      q = '{8'h01, DELIM};
      send_seq(q);
      // type only: zero type and all-ones type
      q = '{ZERO_BYTE};
      send_packet(q);
      q = '{8'hFF};
      send_packet(q);
      // zero insertion between groups
      q = '{8'hA5, ZERO_BYTE, 8'h5A, ZERO_BYTE, ZERO_BYTE, 8'h01};
      send_packet(q);
      // longest payload, all ones, then with zeros
      q.delete();
      repeat (DEC_MAX) q.push_back(8'hFF);
      send_packet(q);
      make_data(DEC_MAX, 25, q);
      send_packet(q);
      // one byte more than the decoded store holds
      make_data(DEC_MAX + 1, 0, q);
      send_packet(q);
      // group announces more data than the frame carries
      q = '{8'h05, 8'h11, 8'h22, DELIM};
      send_seq(q);
      // 0xFF group: truncated, and no zero inserted
      q = '{CODE_NOZERO, 8'h01, 8'h80, 8'h7F, DELIM};
      send_seq(q);
      // raw store exactly full, then four bytes past full with a stray tail
      make_noise(RAW_MAX, q);
      q.push_back(DELIM);
      send_seq(q);
      make_noise(RAW_MAX + 4, q);
      q.push_back(DELIM);
      q.push_back(DELIM);
      send_seq(q);
      q = '{8'h42, 8'h24};
      send_packet(q);

      // random traffic: mostly well-formed frames, some noise, empty frames and overruns
      while (sent_cnt < 380) begin
         r = $urandom_range(99);
         if (r < 70) begin
            n = ($urandom_range(99) < 85) ? $urandom_range(1, 16)
                                          : $urandom_range(17, DEC_MAX + 1);
            make_data(n, $urandom_range(0, 40), q);
            send_packet(q);
         end else if (r < 90) begin
            make_noise($urandom_range(1, 12), q);
            q.push_back(DELIM);
            send_seq(q);
         end else if (r < 96) begin
            q = '{DELIM};
            send_seq(q);
         end else begin
            make_noise(RAW_MAX + $urandom_range(1, 5), q);
            q.push_back(DELIM);
            send_seq(q);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.beats_due.size() != 0)
         @(posedge clock);
      repeat (3 * (RAW_MAX + DEC_MAX)) @(posedge clock);

      if (sb.errors == 0 && sb.beats_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (sb.beats_due.size() != 0)
            $error("%0d expected beats never arrived", sb.beats_due.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
